>>> hdl/rnpp_pkg.sv
// Shared constants, codes and control/status types of the ray nearest-point pick block.
// No dependencies; every other file of the block imports this package.
package rnpp_pkg;

  localparam int COORD_BITS = 24;
  localparam int SET_BITS   = 16;
  localparam int POINT_BITS = 20;
  localparam int METRIC_BITS = 64;

  localparam int IN_DATA_BITS  = 6 * COORD_BITS;
  localparam int OUT_DATA_BITS = ((SET_BITS + POINT_BITS + 7) / 8) * 8;

  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORG_X = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORG_Y = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORG_Z = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIR_X = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIR_Y = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIR_Z = 3'd5;
  localparam logic [COORD_BITS-1:0] DIR_Y_RESET = COORD_BITS'(1024);

  // Operand and product widths.
  localparam int VW    = COORD_BITS + 3;      // signed offset vector
  localparam int MVW   = VW - 1;              // its magnitude
  localparam int MRW   = COORD_BITS + 1;      // box extent magnitude
  localparam int KW    = 2 * COORD_BITS + 2;  // |dir|^2
  localparam int K9W   = KW + 4;              // 9*|dir|^2
  localparam int QW    = 2 * COORD_BITS + 6;  // |v|^2
  localparam int RW    = 2 * COORD_BITS + 4;  // |max-min|^2
  localparam int DOTW  = 2 * COORD_BITS + 5;  // signed dir.v
  localparam int DIGIT = 8;
  localparam int MDIGITS = (2 * COORD_BITS + 15) / DIGIT;
  localparam int MB_BITS = MDIGITS * DIGIT;
  localparam int MA_BITS = 4 * COORD_BITS + 8;
  localparam int MP_BITS = MA_BITS + MB_BITS;
  localparam int CNT_BITS = $clog2(MDIGITS);

  typedef enum logic [3:0] {
    OP_K0, OP_K1, OP_K2,
    OP_Q0, OP_Q1, OP_Q2,
    OP_D0, OP_D1, OP_D2,
    OP_R0, OP_R1, OP_R2,
    OP_QK, OP_DD, OP_FIN
  } op_t;

  typedef struct packed {
    logic load;
    logic start;
    op_t  op;
    logic wb;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_point;
    logic live;
    logic last;
    logic mul_done;
    logic out_busy;
  } ctl_stat_t;

endpackage

>>> hdl/ray_nearest_point_pick.sv
// Top level of the ray nearest-point pick block: ports, controller and datapath.
// Depends on rnpp_pkg, rnpp_ctrl and rnpp_datapath (which holds rnpp_mul).
//
//   Channel   Direction  Transfer when             Carries
//   cfg       in         cfg_valid & cfg_ready     register index and 24-bit value
//   s_axis    in         s_axis_tvalid & tready    header or point item, tlast ends a pick
//   m_axis    out        m_axis_tvalid & tready    hit flag and best set/point index
//
// One item is worked at a time. The cost is set by the shared 104x8 multiplier, which
// runs each wide product as issue, seven digit steps and write-back. A header uses
// 15 products; a point of a live set uses 12 products; a point of a culled set uses
// no products and goes straight from load to commit.
// Reset is synchronous and restores the ray registers to origin zero, direction (0,1024,0).
// A stalled result waits in the output register while the next item is taken; only a
// second final item stalls until that result has been transferred.
module ray_nearest_point_pick import rnpp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // From bit 0 up: a_x, a_y, a_z, b_x, b_y, b_z.
  input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
  // opcode: 0 = set header, 1 = point.
  input  logic                      s_axis_tuser,
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // From bit 0 up: best_set, best_point, zero padding.
  output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
  // hit.
  output logic                      m_axis_tuser
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Register writes are taken in any cycle; the user must issue them only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  rnpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rnpp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .s_tlast   (s_axis_tlast),
    .m_tready  (m_axis_tready),
    .m_tvalid  (m_axis_tvalid),
    .m_tdata   (m_axis_tdata),
    .m_tuser   (m_axis_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> hdl/rnpp_mul.sv
// Multi-cycle wide unsigned multiplier, one 8-bit digit of the B operand per cycle.
// Depends on rnpp_pkg for widths.
module rnpp_mul import rnpp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MA_BITS-1:0] a,
  input  logic [MB_BITS-1:0] b,
  output logic               done,
  output logic [MP_BITS-1:0] p
);

  logic [MA_BITS-1:0]  a_r;
  logic [MB_BITS-1:0]  b_r;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(MDIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Each partial product enters at the top and drifts right one digit per step.
  // The A operand is widened by one digit so the partial product keeps its carry.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p   <= '0;
    end else if (busy) begin
      p   <= (p >> DIGIT) +
             (MP_BITS'({{DIGIT{1'b0}}, a_r} * b_r[DIGIT-1:0]) << (MB_BITS - DIGIT));
      b_r <= b_r >> DIGIT;
    end
  end

endmodule

>>> hdl/rnpp_datapath.sv
// Datapath: ray registers, item latch, operand select, shared multiplier and pick state.
// Depends on rnpp_pkg and rnpp_mul.
module rnpp_datapath import rnpp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data,
  input  logic [IN_DATA_BITS-1:0]   s_tdata,
  input  logic                      s_tuser,
  input  logic                      s_tlast,
  input  logic                      m_tready,
  output logic                      m_tvalid,
  output logic [OUT_DATA_BITS-1:0]  m_tdata,
  output logic                      m_tuser,
  input  ctl_cmd_t                  cmd,
  output ctl_stat_t                 stat
);

  logic signed [COORD_BITS-1:0] org [3];
  logic signed [COORD_BITS-1:0] dir [3];
  logic [COORD_BITS-1:0] md [3];
  logic [2:0] dneg;

  logic [MVW-1:0] mv [3];
  logic [MRW-1:0] mr [3];
  logic [2:0] vneg;
  logic is_point, last_r;

  logic [KW-1:0]  k, kk;
  logic [K9W-1:0] k9;
  logic [QW-1:0]  q;
  logic [RW-1:0]  r2;
  logic signed [DOTW-1:0] dot, term;
  logic [DOTW-2:0] dmag;
  logic [MA_BITS-1:0] t;
  logic [METRIC_BITS-1:0] metric;
  logic live_new;

  logic [METRIC_BITS-1:0] best_metric, n_metric;
  logic [SET_BITS-1:0]    best_set, set_cnt, n_bset, n_set;
  logic [POINT_BITS-1:0]  best_pt, pt_cnt, n_bpt, n_pt;
  logic hit, live, n_hit, n_live;
  logic [SET_BITS-1:0]   out_set;
  logic [POINT_BITS-1:0] out_pt;
  logic out_hit;

  logic [MA_BITS-1:0] op_a;
  logic [MB_BITS-1:0] op_b;
  logic               mul_done;
  logic [MP_BITS-1:0] p;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= DIR_Y_RESET;
      dir[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORG_X: org[0] <= cfg_data;
        REG_ORG_Y: org[1] <= cfg_data;
        REG_ORG_Z: org[2] <= cfg_data;
        REG_DIR_X: dir[0] <= cfg_data;
        REG_DIR_Y: dir[1] <= cfg_data;
        REG_DIR_Z: dir[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dneg[i] = dir[i][COORD_BITS-1];
      md[i]   = dneg[i] ? COORD_BITS'(-dir[i]) : COORD_BITS'(dir[i]);
    end
  end

  // Latch the item: offset from the origin (doubled box center for a header) and extent.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_point <= s_tuser;
      last_r   <= s_tlast;
      for (int i = 0; i < 3; i++) begin
        logic signed [COORD_BITS-1:0] ai, bi;
        logic signed [VW-1:0] vs;
        logic signed [MRW-1:0] rs;
        ai = s_tdata[i*COORD_BITS +: COORD_BITS];
        bi = s_tdata[(3+i)*COORD_BITS +: COORD_BITS];
        if (s_tuser) vs = VW'(ai) - VW'(org[i]);
        else         vs = VW'(ai) + VW'(bi) - (VW'(org[i]) <<< 1);
        rs = MRW'(bi) - MRW'(ai);
        vneg[i] <= vs[VW-1];
        mv[i]   <= vs[VW-1] ? MVW'(-vs) : MVW'(vs);
        mr[i]   <= rs[MRW-1] ? MRW'(-rs) : MRW'(rs);
      end
    end
  end

  assign kk   = (k == '0) ? KW'(1) : k;
  assign k9   = {kk, 3'b000} + K9W'(kk);
  assign dmag = dot[DOTW-1] ? (DOTW-1)'(-dot) : (DOTW-1)'(dot);

  always_comb begin
    case (cmd.op)
      OP_K0: begin op_a = MA_BITS'(md[0]); op_b = MB_BITS'(md[0]); end
      OP_K1: begin op_a = MA_BITS'(md[1]); op_b = MB_BITS'(md[1]); end
      OP_K2: begin op_a = MA_BITS'(md[2]); op_b = MB_BITS'(md[2]); end
      OP_Q0: begin op_a = MA_BITS'(mv[0]); op_b = MB_BITS'(mv[0]); end
      OP_Q1: begin op_a = MA_BITS'(mv[1]); op_b = MB_BITS'(mv[1]); end
      OP_Q2: begin op_a = MA_BITS'(mv[2]); op_b = MB_BITS'(mv[2]); end
      OP_D0: begin op_a = MA_BITS'(md[0]); op_b = MB_BITS'(mv[0]); end
      OP_D1: begin op_a = MA_BITS'(md[1]); op_b = MB_BITS'(mv[1]); end
      OP_D2: begin op_a = MA_BITS'(md[2]); op_b = MB_BITS'(mv[2]); end
      OP_R0: begin op_a = MA_BITS'(mr[0]); op_b = MB_BITS'(mr[0]); end
      OP_R1: begin op_a = MA_BITS'(mr[1]); op_b = MB_BITS'(mr[1]); end
      OP_R2: begin op_a = MA_BITS'(mr[2]); op_b = MB_BITS'(mr[2]); end
      OP_QK: begin op_a = MA_BITS'(q);     op_b = MB_BITS'(kk);    end
      OP_DD: begin op_a = MA_BITS'(dmag);  op_b = MB_BITS'(dmag);  end
      default: begin
        if (is_point) begin
          op_a = t;
          op_b = MB_BITS'(q);
        end else begin
          op_a = MA_BITS'(k9);
          op_b = MB_BITS'(r2);
        end
      end
    endcase
  end

  rnpp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .p     (p)
  );

  assign term = DOTW'(p);

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      case (cmd.op)
        OP_K0: k <= KW'(p);
        OP_K1, OP_K2: k <= k + KW'(p);
        OP_Q0: q <= QW'(p);
        OP_Q1, OP_Q2: q <= q + QW'(p);
        OP_D0: dot <= (dneg[0] ^ vneg[0]) ? -term : term;
        OP_D1: dot <= (dneg[1] ^ vneg[1]) ? dot - term : dot + term;
        OP_D2: dot <= (dneg[2] ^ vneg[2]) ? dot - term : dot + term;
        OP_R0: r2 <= RW'(p);
        OP_R1, OP_R2: r2 <= r2 + RW'(p);
        OP_QK: t <= MA_BITS'(p);
        OP_DD: t <= t - MA_BITS'(p);
        default: begin
          if (is_point) begin
            metric <= (|p[MP_BITS-1:METRIC_BITS]) ? '1 : p[METRIC_BITS-1:0];
          end else begin
            // Sphere test in doubled coordinates: 4*t <= 9*k*r2.
            live_new <= MP_BITS'({t, 2'b00}) <= p;
          end
        end
      endcase
    end
  end

  always_comb begin
    n_metric = best_metric;
    n_bset   = best_set;
    n_bpt    = best_pt;
    n_hit    = hit;
    n_set    = set_cnt;
    n_pt     = pt_cnt;
    n_live   = live;
    if (!is_point) begin
      n_set  = set_cnt + 1'b1;
      n_pt   = '0;
      n_live = live_new;
    end else begin
      if (live && (metric < best_metric)) begin
        n_metric = metric;
        n_bset   = set_cnt;
        n_bpt    = pt_cnt;
        n_hit    = 1'b1;
      end
      n_pt = pt_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_metric <= '1;
      best_set    <= '0;
      best_pt     <= '0;
      hit         <= 1'b0;
      set_cnt     <= '1;
      pt_cnt      <= '0;
      live        <= 1'b0;
    end else if (cmd.commit) begin
      if (last_r) begin
        best_metric <= '1;
        best_set    <= '0;
        best_pt     <= '0;
        hit         <= 1'b0;
        set_cnt     <= '1;
        pt_cnt      <= '0;
        live        <= 1'b0;
      end else begin
        best_metric <= n_metric;
        best_set    <= n_bset;
        best_pt     <= n_bpt;
        hit         <= n_hit;
        set_cnt     <= n_set;
        pt_cnt      <= n_pt;
        live        <= n_live;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit && last_r) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && last_r) begin
      out_hit <= n_hit;
      out_set <= n_bset;
      out_pt  <= n_bpt;
    end
  end

  assign m_tuser = out_hit;
  assign m_tdata = OUT_DATA_BITS'({out_pt, out_set});

  assign stat.is_point = is_point;
  assign stat.live     = live;
  assign stat.last     = last_r;
  assign stat.mul_done = mul_done;
  assign stat.out_busy = m_tvalid & ~m_tready;

endmodule

>>> hdl/rnpp_ctrl.sv
// Controller: sequences the multiply steps for one item and commits its result.
// Depends on rnpp_pkg for the command, status and step codes.
module rnpp_ctrl import rnpp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next, op_succ;
  logic   commit;

  // A point only needs the line term and the final score; the extent steps are header-only.
  always_comb begin
    unique case (op)
      OP_K0: op_succ = OP_K1;
      OP_K1: op_succ = OP_K2;
      OP_K2: op_succ = OP_Q0;
      OP_Q0: op_succ = OP_Q1;
      OP_Q1: op_succ = OP_Q2;
      OP_Q2: op_succ = OP_D0;
      OP_D0: op_succ = OP_D1;
      OP_D1: op_succ = OP_D2;
      OP_D2: op_succ = stat.is_point ? OP_QK : OP_R0;
      OP_R0: op_succ = OP_R1;
      OP_R1: op_succ = OP_R2;
      OP_R2: op_succ = OP_QK;
      OP_QK: op_succ = OP_DD;
      default: op_succ = OP_FIN;
    endcase
  end

  assign commit = (state == S_DONE) && !(stat.last && stat.out_busy);

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_LOAD;
      S_LOAD: begin
        if (stat.is_point && !stat.live) begin
          state_next = S_DONE;
        end else begin
          op_next    = OP_K0;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: state_next = S_WAIT;
      S_WAIT: begin
        if (stat.mul_done) begin
          if (op == OP_FIN) begin
            state_next = S_DONE;
          end else begin
            op_next    = op_succ;
            state_next = S_ISSUE;
          end
        end
      end
      S_DONE: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_K0;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign s_tready   = (state == S_IDLE);
  assign cmd.load   = s_tvalid && (state == S_IDLE);
  assign cmd.start  = (state == S_ISSUE);
  assign cmd.op     = op;
  assign cmd.wb     = (state == S_WAIT) && stat.mul_done;
  assign cmd.commit = commit;

endmodule

>>> hdl/rnpp_check.sv
// Port-level checker for the ray nearest-point pick block, bound to the top level.
// Depends on rnpp_pkg for port widths.
module rnpp_check import rnpp_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
  input logic                      m_axis_tuser
);

  // A result waits until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  // One item at a time: an input transfer closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // A miss reports zero indices.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss carries nonzero indices");

  // No result right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result present after reset");

endmodule

bind ray_nearest_point_pick rnpp_check u_check (.*);
